[design/btim_pkg.sv]
// Shared types and constants for the bucketed tag id mapper.
// No dependencies; imported by every module of the block.
package btim_pkg;

   localparam int BUCKET_SLOTS      = 64;
   localparam int SLOT_BITS         = 6;
   localparam int TAG_BITS          = 8;
   localparam int ROW_BITS          = BUCKET_SLOTS * TAG_BITS;
   localparam int INDEX_BITS        = 12;
   localparam int POS_BITS          = 16;
   localparam int ID_BITS           = 18;
   localparam int STATUS_BITS       = 2;
   localparam int STORE_ENTRIES_DEF = 4096;

   localparam logic [TAG_BITS-1:0] TAG_EMPTY = 8'hFF;

   localparam logic [STATUS_BITS-1:0] STATUS_FOUND    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_INSERTED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd2;

   typedef struct packed {
      logic [SLOT_BITS-1:0]   probe;   // probe count to the stop slot
      logic [SLOT_BITS-1:0]   slot;    // slot inside the bucket
      logic [STATUS_BITS-1:0] status;
      logic                   wr_en;   // row must be written back
   } probe_res_type;

endpackage

[design/bucketed_tag_id_mapper_unit.sv]
// Bucketed tag id mapper: top level with control sequencer and result register.
// Depends on btim_pkg, btim_row_store and btim_probe.
// The result strobe comes from the result register, which follows the registered row read.
// One item at a time (row read, then compare and write-back); busy is high meanwhile.
// Reset: synchronous; a clearing pass over all STORE_ENTRIES/64 rows (64 by default)
// fills the store with empty tags, busy stays high until it ends.
// Results cannot be stalled by the receiver.
module bucketed_tag_id_mapper_unit import btim_pkg::*; #(
   parameter int STORE_ENTRIES = STORE_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [INDEX_BITS-1:0]  req_start_index,
   input  logic [TAG_BITS-1:0]    req_tag,
   input  logic [POS_BITS-1:0]    req_batch_position,
   output logic                   rsp_valid,
   output logic [POS_BITS-1:0]    rsp_result_position,
   output logic [ID_BITS-1:0]     rsp_mapped_id,
   output logic [STATUS_BITS-1:0] rsp_status
);

   // whole buckets only; trailing entries are never used
   localparam int BucketCount = STORE_ENTRIES / BUCKET_SLOTS;
   localparam int RowW        = (BucketCount > 1) ? $clog2(BucketCount) : 1;
   localparam int HiBits      = INDEX_BITS - SLOT_BITS;
   localparam int HiRows      = 1 << HiBits;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [RowW-1:0]       clr_ff, clr_in;
   logic [RowW-1:0]       row_ff;
   logic [INDEX_BITS-1:0] index_ff;
   logic [TAG_BITS-1:0]   tag_ff;
   logic [POS_BITS-1:0]   pos_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0]    rsp_pos_ff;
   logic [ID_BITS-1:0]     rsp_id_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;

   logic                accept;
   logic                clearing;
   logic                looking;
   logic [RowW-1:0]     row_wrap [HiRows];
   logic [RowW-1:0]     req_row;
   logic [ROW_BITS-1:0] rd_row;
   logic [ROW_BITS-1:0] new_row;
   logic                wr_en;
   logic [RowW-1:0]     wr_addr;
   logic [ROW_BITS-1:0] wr_data;
   probe_res_type       pres;

   assign clearing = state_ff == ST_CLEAR;
   assign looking  = state_ff == ST_LOOK;
   assign busy     = state_ff != ST_IDLE;
   assign accept   = start && !busy;

   // bucket number wraps over the whole buckets of the store;
   // constant table indexed by the upper bits of the start index
   always_comb begin
      for (int b = 0; b < HiRows; b++) begin
         row_wrap[b] = RowW'(b % BucketCount);
      end
   end

   assign req_row = row_wrap[req_start_index[INDEX_BITS-1:SLOT_BITS]];

   // ---------------------------------------------------------------- sequencer
   // CLEAR sweeps every row to empty, IDLE takes an item and issues the row read,
   // LOOK resolves the probe on the returned row and writes it back.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == RowW'(BucketCount - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // item fields held for the lookup cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff   <= req_row;
         index_ff <= req_start_index;
         tag_ff   <= req_tag;
         pos_ff   <= req_batch_position;
      end
   end

   // ---------------------------------------------------------------- storage
   btim_row_store #(
      .ROWS   (BucketCount),
      .ADDR_W (RowW)
   ) u_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_row),
      .rd_data (rd_row),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   btim_probe u_probe (
      .row    (rd_row),
      .offset (index_ff[SLOT_BITS-1:0]),
      .tag    (tag_ff),
      .res    (pres)
   );

   // insert the tag at the stop slot; a reserved tag leaves the slot empty anyway
   always_comb begin
      for (int s = 0; s < BUCKET_SLOTS; s++) begin
         if (pres.slot == SLOT_BITS'(s)) begin
            new_row[s*TAG_BITS +: TAG_BITS] = tag_ff;
         end else begin
            new_row[s*TAG_BITS +: TAG_BITS] = rd_row[s*TAG_BITS +: TAG_BITS];
         end
      end
   end

   // next item is read no earlier than the cycle after this write: no overlap
   assign wr_en   = clearing || (looking && pres.wr_en);
   assign wr_addr = clearing ? clr_ff : row_ff;
   assign wr_data = clearing ? {BUCKET_SLOTS{TAG_EMPTY}} : new_row;

   // ---------------------------------------------------------------- result
   assign rsp_valid_in = looking;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // id = start_index * 64 + probe; low six bits of the product are zero
   always_ff @(posedge clock) begin
      if (looking) begin
         rsp_pos_ff    <= pos_ff;
         rsp_status_ff <= pres.status;
         if (pres.status == STATUS_FULL) begin
            rsp_id_ff <= '0;
         end else begin
            rsp_id_ff <= {index_ff, pres.probe};
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_position = rsp_pos_ff;
   assign rsp_mapped_id       = rsp_id_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

[design/btim_row_store.sv]
// Tag store: one row per bucket, all tags of a bucket in one wide word.
// Depends on btim_pkg. One write port, one read port with registered data.
module btim_row_store import btim_pkg::*; #(
   parameter int ROWS   = STORE_ENTRIES_DEF / BUCKET_SLOTS,
   parameter int ADDR_W = 6
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [ROW_BITS-1:0] rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [ROW_BITS-1:0] wr_data
);

   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/btim_probe.sv]
// Probe resolution over one bucket row: first empty or matching slot from offset.
// Depends on btim_pkg.
module btim_probe import btim_pkg::*; (
   input  logic [ROW_BITS-1:0]  row,
   input  logic [SLOT_BITS-1:0] offset,
   input  logic [TAG_BITS-1:0]  tag,
   output probe_res_type        res
);

   logic [BUCKET_SLOTS-1:0]   hit;
   logic [BUCKET_SLOTS-1:0]   empty;
   logic [2*BUCKET_SLOTS-1:0] hit_dbl;
   logic [BUCKET_SLOTS-1:0]   rot;
   logic [SLOT_BITS-1:0]      probe;
   logic [SLOT_BITS-1:0]      slot;

   always_comb begin
      for (int s = 0; s < BUCKET_SLOTS; s++) begin
         empty[s] = row[s*TAG_BITS +: TAG_BITS] == TAG_EMPTY;
         hit[s]   = empty[s] || (row[s*TAG_BITS +: TAG_BITS] == tag);
      end
   end

   // rotate so that bit k is the slot reached after k probes
   assign hit_dbl = {hit, hit} >> offset;
   assign rot     = hit_dbl[BUCKET_SLOTS-1:0];

   always_comb begin
      probe = '0;
      for (int k = BUCKET_SLOTS - 1; k >= 0; k--) begin
         if (rot[k]) begin
            probe = SLOT_BITS'(k);
         end
      end
   end

   assign slot = offset + probe;   // wraps inside the bucket

   always_comb begin
      res.probe = probe;
      res.slot  = slot;
      if (!(|rot)) begin
         res.status = STATUS_FULL;
         res.wr_en  = 1'b0;
      end else if (empty[slot]) begin
         res.status = STATUS_INSERTED;
         res.wr_en  = 1'b1;
      end else begin
         res.status = STATUS_FOUND;
         res.wr_en  = 1'b0;
      end
   end

endmodule
